// ===== rtl/core/sm4_block_cipher_unit_assert.svh =====
// Assertion macros for the SM4 block cipher unit
`ifndef SM4_BLOCK_CIPHER_UNIT_ASSERT_SVH
`define SM4_BLOCK_CIPHER_UNIT_ASSERT_SVH
// Implication checked on every clock edge outside reset
`define SM4_ASSERT_IMP(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset
`define SM4_ASSERT_NXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`endif

// ===== rtl/core/sm4_pkg.sv =====
// ----------------------------------------------------------------------------
// sm4_pkg
// Shared types, constants and round functions of the SM4 cipher unit.
// ----------------------------------------------------------------------------
`default_nettype none
package sm4_pkg;

  localparam int RoundCount = 32;
  localparam int RndW       = $clog2(RoundCount);

  // configuration register indexes
  localparam logic [1:0] CfgKeyHigh = 2'd0;
  localparam logic [1:0] CfgKeyLow  = 2'd1;
  localparam logic [1:0] CfgMode    = 2'd2;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 64;

  localparam logic [31:0] Fk0 = 32'ha3b1bac6;
  localparam logic [31:0] Fk1 = 32'h56aa3350;
  localparam logic [31:0] Fk2 = 32'h677d9197;
  localparam logic [31:0] Fk3 = 32'hb27022dc;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_KEYS,
    ST_ROUNDS,
    ST_OUT
  } sm4_state_t;

  // controller to datapath
  typedef struct packed {
    logic            key_load;   // load whitened key words
    logic            key_step;   // one key schedule step
    logic            blk_load;   // load input block
    logic            blk_step;   // one data round
    logic            out_load;   // capture result
    logic [RndW-1:0] rnd;        // round counter
  } sm4_cmd_t;

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] t [256];
    t = '{
      8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
      8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
      8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
      8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
      8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
      8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
      8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
      8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
      8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
      8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
      8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
      8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
      8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
      8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
      8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
      8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
    };
    return t[a];
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] x);
    return {sbox(x[31:24]), sbox(x[23:16]), sbox(x[15:8]), sbox(x[7:0])};
  endfunction

  function automatic logic [31:0] rotl(input logic [31:0] x, input int r);
    return (x << r) | (x >> (32 - r));
  endfunction

  // CK byte j of entry i is (4i+j)*7 mod 256
  function automatic logic [31:0] ck_word(input logic [RndW-1:0] i);
    logic [7:0] b0;
    b0 = {i, 2'b00} * 8'd7;
    return {b0, b0 + 8'd7, b0 + 8'd14, b0 + 8'd21};
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/sm4_if.sv =====
// ----------------------------------------------------------------------------
// sm4_if
// Valid/ready channel carrying one 128-bit block as two 64-bit halves.
// ----------------------------------------------------------------------------
`default_nettype none
interface sm4_if;
  logic        valid;
  logic        ready;
  logic [63:0] high;
  logic [63:0] low;
  modport source (output valid, output high, output low, input ready);
  modport sink (input valid, input high, input low, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/sm4_ram.sv =====
// ----------------------------------------------------------------------------
// sm4_ram
// Generic single-port write, single-port read RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module sm4_ram #(
  parameter int Width = 32,
  parameter int Depth = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== rtl/core/sm4_ctrl.sv =====
// ----------------------------------------------------------------------------
// sm4_ctrl
// Sequencer: key schedule on stale keys, 32 data rounds, result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none
module sm4_ctrl
  import sm4_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     cfg_hit,
  input  wire logic     in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  wire logic     out_ready,
  output sm4_cmd_t      cmd
);
  sm4_state_t      state_r, state_nxt;
  logic [RndW-1:0] rnd_r, rnd_nxt;
  logic            keys_ok_r, keys_ok_nxt;
  logic            full_r, full_nxt;
  logic            last;

  assign last = (rnd_r == RndW'(RoundCount - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      rnd_r     <= '0;
      keys_ok_r <= 1'b0;
      full_r    <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      rnd_r     <= rnd_nxt;
      keys_ok_r <= keys_ok_nxt;
      full_r    <= full_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt   = state_r;
    rnd_nxt     = rnd_r;
    keys_ok_nxt = keys_ok_r & ~cfg_hit;
    full_nxt    = full_r;
    cmd         = '0;
    cmd.rnd     = rnd_r;
    in_ready    = 1'b0;
    if (full_r && out_ready) begin
      full_nxt = 1'b0;
    end
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.blk_load = 1'b1;
          rnd_nxt      = '0;
          if (keys_ok_r) begin
            state_nxt = ST_ROUNDS;
          end else begin
            cmd.key_load = 1'b1;
            state_nxt    = ST_KEYS;
          end
        end
      end
      ST_KEYS: begin
        cmd.key_step = 1'b1;
        rnd_nxt      = rnd_r + 1'b1;
        if (last) begin
          keys_ok_nxt = 1'b1;
          state_nxt   = ST_ROUNDS;
        end
      end
      ST_ROUNDS: begin
        cmd.blk_step = 1'b1;
        rnd_nxt      = rnd_r + 1'b1;
        if (last) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        // wait for the result register to drain
        if (!full_r || out_ready) begin
          cmd.out_load = 1'b1;
          full_nxt     = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_valid = full_r;
endmodule
`default_nettype wire

// ===== rtl/core/sm4_dp.sv =====
// ----------------------------------------------------------------------------
// sm4_dp
// Datapath: config registers, key schedule, round key RAM, round unit.
// ----------------------------------------------------------------------------
`default_nettype none
module sm4_dp
  import sm4_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_we,
  input  wire logic [CfgIdxW-1:0]  cfg_idx,
  input  wire logic [CfgDataW-1:0] cfg_data,
  input  sm4_cmd_t                 cmd,
  input  wire logic [63:0]         blk_high,
  input  wire logic [63:0]         blk_low,
  output logic      [63:0]         res_high,
  output logic      [63:0]         res_low
);
  logic [63:0] key_high_r, key_low_r;
  logic        mode_r;
  logic [31:0] k_r [4];
  logic [31:0] w_r [4];
  logic [31:0] rk_new, rk_rd, rk_use, t_data, w_new;
  logic [RndW-1:0] raddr;
  logic        byp_r;

  // config registers, cleared on reset, held between writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_high_r <= '0;
      key_low_r  <= '0;
      mode_r     <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CfgKeyHigh: key_high_r <= cfg_data;
        CfgKeyLow:  key_low_r  <= cfg_data;
        CfgMode:    mode_r     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // key schedule step
  assign rk_new = k_r[0] ^ (sub_word(k_r[1] ^ k_r[2] ^ k_r[3] ^ ck_word(cmd.rnd)) ^
                  rotl(sub_word(k_r[1] ^ k_r[2] ^ k_r[3] ^ ck_word(cmd.rnd)), 13) ^
                  rotl(sub_word(k_r[1] ^ k_r[2] ^ k_r[3] ^ ck_word(cmd.rnd)), 23));

  always_ff @(posedge clk) begin
    if (cmd.key_load) begin
      k_r[0] <= key_high_r[63:32] ^ Fk0;
      k_r[1] <= key_high_r[31:0] ^ Fk1;
      k_r[2] <= key_low_r[63:32] ^ Fk2;
      k_r[3] <= key_low_r[31:0] ^ Fk3;
    end else if (cmd.key_step) begin
      k_r[0] <= k_r[1];
      k_r[1] <= k_r[2];
      k_r[2] <= k_r[3];
      k_r[3] <= rk_new;
    end
  end

  // last key step just done: its key sits in k_r[3], not yet readable
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byp_r <= 1'b0;
    end else begin
      byp_r <= cmd.key_step && (cmd.rnd == RndW'(RoundCount - 1));
    end
  end

  // read address leads the round by one (registered read)
  always_comb begin
    logic [RndW-1:0] nxt;
    nxt = cmd.blk_load ? '0 : cmd.rnd + 1'b1;
    raddr = mode_r ? ~nxt : nxt;
  end

  sm4_ram #(.Width(32), .Depth(RoundCount)) u_rk_ram (
    .clk   (clk),
    .we    (cmd.key_step),
    .waddr (cmd.rnd),
    .wdata (rk_new),
    .raddr (raddr),
    .rdata (rk_rd)
  );

  // decrypt starts with the key written on the same edge it was read
  assign rk_use = (byp_r && mode_r) ? k_r[3] : rk_rd;

  // data round
  always_comb begin
    logic [31:0] s;
    t_data = w_r[1] ^ w_r[2] ^ w_r[3] ^ rk_use;
    s      = sub_word(t_data);
    w_new  = w_r[0] ^ s ^ rotl(s, 2) ^ rotl(s, 10) ^ rotl(s, 18) ^ rotl(s, 24);
  end

  always_ff @(posedge clk) begin
    if (cmd.blk_load) begin
      w_r[0] <= blk_high[63:32];
      w_r[1] <= blk_high[31:0];
      w_r[2] <= blk_low[63:32];
      w_r[3] <= blk_low[31:0];
    end else if (cmd.blk_step) begin
      w_r[0] <= w_r[1];
      w_r[1] <= w_r[2];
      w_r[2] <= w_r[3];
      w_r[3] <= w_new;
    end
    if (cmd.out_load) begin
      res_high <= {w_r[3], w_r[2]};
      res_low  <= {w_r[1], w_r[0]};
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/sm4_block_cipher_unit.sv =====
// ----------------------------------------------------------------------------
// sm4_block_cipher_unit
// SM4 128-bit block cipher with on-demand key schedule.
// ----------------------------------------------------------------------------
//  channel | direction | handshake      | payload
//  in      | sink      | in_valid/ready | in_block_high, in_block_low
//  out     | source    | out_valid/ready| out_result_high, out_result_low
//  cfg     | write     | cfg_we         | cfg_index, cfg_data
//
// A block passes through the accept state, the 32 data rounds and the result
// state; the first request after reset or a write to a known config index
// runs the key schedule before its rounds. Rate is set by the single shared
// round unit and the round-key RAM read port. Reset is synchronous and clears
// control and the config registers. A stalled result waits in the output
// register while the next block runs.
`default_nettype none
module sm4_block_cipher_unit
  import sm4_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_we,
  input  wire logic [CfgIdxW-1:0]  cfg_index,
  input  wire logic [CfgDataW-1:0] cfg_data,
  sm4_if.sink                      in_blk,
  sm4_if.source                    out_res
);
  sm4_cmd_t cmd;
  logic     cfg_hit;

  // only known indexes mark keys stale
  assign cfg_hit = cfg_we && (cfg_index == CfgKeyHigh || cfg_index == CfgKeyLow ||
                              cfg_index == CfgMode);

  sm4_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_hit   (cfg_hit),
    .in_valid  (in_blk.valid),
    .in_ready  (in_blk.ready),
    .out_valid (out_res.valid),
    .out_ready (out_res.ready),
    .cmd       (cmd)
  );

  sm4_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_index),
    .cfg_data (cfg_data),
    .cmd      (cmd),
    .blk_high (in_blk.high),
    .blk_low  (in_blk.low),
    .res_high (out_res.high),
    .res_low  (out_res.low)
  );
endmodule
`default_nettype wire

// ===== rtl/core/sm4_chk.sv =====
// ----------------------------------------------------------------------------
// sm4_chk
// Port-level checks on the SM4 cipher unit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "sm4_block_cipher_unit_assert.svh"
module sm4_chk (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready
);
  // a block in flight cannot be accepted again next cycle
  `SM4_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)
  // a stalled result stays offered
  `SM4_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
  // no result appears straight after an accept
  `SM4_ASSERT_NXT(a_no_instant_out, clk, rst_n, in_valid && in_ready && !out_valid,
                  !out_valid)
endmodule

bind sm4_block_cipher_unit sm4_chk u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_blk.valid),
  .in_ready  (in_blk.ready),
  .out_valid (out_res.valid),
  .out_ready (out_res.ready)
);
`default_nettype wire

// ===== sim/tb_sm4_block_cipher_unit.sv =====
// ----------------------------------------------------------------------------
// tb_sm4_block_cipher_unit
// Self-checking bench for the SM4 cipher unit: key and direction settings,
// directed corner blocks, then random blocks under varied handshake idling.
// ----------------------------------------------------------------------------
`default_nettype none

class sm4_scoreboard;
  logic [63:0] key_hi, key_lo;
  bit          dec_mode;
  bit          keys_fresh;
  logic [31:0] rkeys [32];
  logic [127:0] pending [$];
  int          fails;
  int          checked;

  function new();
    key_hi = '0;
    key_lo = '0;
    dec_mode = 1'b0;
    keys_fresh = 1'b0;
    fails = 0;
    checked = 0;
  endfunction

  static function logic [7:0] sb(input logic [7:0] a);
    logic [7:0] t [256];
    t = '{
      8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
      8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
      8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
      8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
      8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
      8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
      8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
      8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
      8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
      8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
      8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
      8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
      8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
      8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
      8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
      8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
    };
    return t[a];
  endfunction

  static function logic [31:0] tau(input logic [31:0] x);
    return {sb(x[31:24]), sb(x[23:16]), sb(x[15:8]), sb(x[7:0])};
  endfunction

  static function logic [31:0] rol(input logic [31:0] x, input int r);
    return {x, x} >> (32 - r);
  endfunction

  // register write as the block sees it; unknown indexes change nothing
  function void write_reg(input logic [1:0] idx, input logic [63:0] val);
    case (idx)
      sm4_pkg::CfgKeyHigh: key_hi = val;
      sm4_pkg::CfgKeyLow:  key_lo = val;
      sm4_pkg::CfgMode:    dec_mode = val[0];
      default: return;
    endcase
    keys_fresh = 1'b0;
  endfunction

  // key expansion with FK whitening and CK constants
  function void expand_key();
    logic [31:0] k [4];
    logic [31:0] ck, b, rk;
    logic [7:0]  c0;
    k[0] = key_hi[63:32] ^ sm4_pkg::Fk0;
    k[1] = key_hi[31:0]  ^ sm4_pkg::Fk1;
    k[2] = key_lo[63:32] ^ sm4_pkg::Fk2;
    k[3] = key_lo[31:0]  ^ sm4_pkg::Fk3;
    for (int i = 0; i < 32; i++) begin
      c0 = 8'(i * 28);
      ck = {c0, c0 + 8'd7, c0 + 8'd14, c0 + 8'd21};
      b = tau(k[1] ^ k[2] ^ k[3] ^ ck);
      rk = k[0] ^ b ^ rol(b, 13) ^ rol(b, 23);
      rkeys[i] = rk;
      k[0] = k[1]; k[1] = k[2]; k[2] = k[3]; k[3] = rk;
    end
    keys_fresh = 1'b1;
  endfunction

  // note an accepted request and queue its cipher output
  function void note_request(input logic [63:0] hi, input logic [63:0] lo);
    logic [31:0] x [4];
    logic [31:0] b, nw;
    if (!keys_fresh) expand_key();
    x[0] = hi[63:32]; x[1] = hi[31:0]; x[2] = lo[63:32]; x[3] = lo[31:0];
    for (int i = 0; i < sm4_pkg::RoundCount; i++) begin
      b = tau(x[1] ^ x[2] ^ x[3] ^ rkeys[dec_mode ? 31 - i : i]);
      nw = x[0] ^ b ^ rol(b, 2) ^ rol(b, 10) ^ rol(b, 18) ^ rol(b, 24);
      x[0] = x[1]; x[1] = x[2]; x[2] = x[3]; x[3] = nw;
    end
    pending.push_back({x[3], x[2], x[1], x[0]});
  endfunction

  function void check_result(input logic [63:0] hi, input logic [63:0] lo);
    logic [127:0] exp_blk;
    if (pending.size() == 0) begin
      $error("unexpected result %h_%h", hi, lo);
      fails++;
      return;
    end
    exp_blk = pending.pop_front();
    checked++;
    if (hi !== exp_blk[127:64]) begin
      $error("result_high: expected %h, got %h", exp_blk[127:64], hi);
      fails++;
    end
    if (lo !== exp_blk[63:0]) begin
      $error("result_low: expected %h, got %h", exp_blk[63:0], lo);
      fails++;
    end
  endfunction
endclass

module tb_sm4_block_cipher_unit;
  import sm4_pkg::*;

  localparam int CycleLimit = 2_000_000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  sm4_if in_blk ();
  sm4_if out_res ();

  sm4_block_cipher_unit dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_blk(in_blk.sink), .out_res(out_res.source)
  );

  sm4_scoreboard cipher_sb = new();
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int cycles = 0;
  int configs = 0;

  always #1 clk = ~clk;

  initial begin
    in_blk.valid = 1'b0;
    in_blk.high = '0;
    in_blk.low = '0;
    out_res.ready = 1'b0;
  end

  // result side: ready changes on the falling edge, results taken on rising
  always @(negedge clk)
    out_res.ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);

  always @(posedge clk)
    if (rst_n && out_res.valid && out_res.ready)
      cipher_sb.check_result(out_res.high, out_res.low);

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("status: fail");
      $finish;
    end
  end

  // request side driven at the falling edge; back-to-back calls share it
  task automatic send_block(input logic [63:0] hi, input logic [63:0] lo);
    while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    in_blk.valid = 1'b1;
    in_blk.high = hi;
    in_blk.low = lo;
    @(posedge clk);
    while (!in_blk.ready) @(posedge clk);
    cipher_sb.note_request(hi, lo);
    @(negedge clk);
    in_blk.valid = 1'b0;
  endtask

  // wait until every queued result is back, plus a latency margin
  task automatic drain();
    while (cipher_sb.pending.size() != 0) @(negedge clk);
    repeat (80) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [63:0] val);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(posedge clk);
    cipher_sb.write_reg(idx, val);
    @(negedge clk);
    cfg_we = 1'b0;
    configs++;
  endtask

  function automatic logic [63:0] rnd64();
    return {$urandom(), $urandom()};
  endfunction

  task automatic rekey(input logic [63:0] kh, input logic [63:0] kl, input logic [63:0] md);
    drain();
    write_reg(CfgKeyHigh, kh);
    write_reg(CfgKeyLow, kl);
    write_reg(CfgMode, md);
  endtask

  task automatic random_phase(input int n);
    logic [63:0] kh, kl, hi, lo;
    int pick;
    for (int i = 0; i < n; i++) begin
      // occasional reconfiguration with varied key shapes
      if ($urandom_range(39) == 0) begin
        pick = $urandom_range(3);
        kh = (pick == 0) ? '0 : (pick == 1) ? '1 : rnd64();
        kl = (pick == 0) ? '1 : rnd64();
        drain();
        case ($urandom_range(3))
          0: write_reg(CfgKeyHigh, kh);
          1: write_reg(CfgKeyLow, kl);
          2: write_reg(CfgMode, rnd64());
          default: write_reg(2'd3, rnd64());
        endcase
      end
      pick = $urandom_range(9);
      hi = (pick == 0) ? '0 : (pick == 1) ? '1 : rnd64();
      lo = (pick == 2) ? '0 : (pick == 3) ? '1 : rnd64();
      send_block(hi, lo);
      if (i == n / 2) drain();
    end
  endtask

  initial begin
    logic [127:0] ct;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: reset key, standard test vector, both directions, extremes
    send_block('0, '0);
    rekey(64'h0123456789abcdef, 64'hfedcba9876543210, 64'd0);
    send_block(64'h0123456789abcdef, 64'hfedcba9876543210);
    drain();
    ct = {cipher_sb.rkeys[0], cipher_sb.rkeys[1], cipher_sb.rkeys[2], cipher_sb.rkeys[3]};
    send_block('1, '1);
    send_block(64'h8000000000000000, 64'h0000000000000001);
    rekey(64'h0123456789abcdef, 64'hfedcba9876543210, 64'hffff_fffe_0000_0001);
    send_block(64'h681edf34d206965e, 64'h86b3e94f536e4246);
    send_block(ct[127:64], ct[63:0]);
    // unknown index leaves keys intact; wide mode keeps bit 0 only
    drain();
    write_reg(2'd3, '1);
    send_block(64'h5555aaaa5555aaaa, 64'haaaa5555aaaa5555);
    rekey('1, '1, 64'h2);
    send_block('0, '1);
    send_block('1, '0);
    rekey('0, '1, 64'h1);
    send_block(64'h0123456789abcdef, '0);
    // keys stale again: one key half rewritten alone
    drain();
    write_reg(CfgKeyLow, 64'h0f0f0f0f0f0f0f0f);
    send_block('0, 64'h00000000ffffffff);
    send_block(64'hffffffff00000000, '0);

    // random phases with changing idling
    send_idle_pct = 27; recv_idle_pct = 71;
    random_phase(520);
    drain();
    send_idle_pct = 71; recv_idle_pct = 27;
    rekey(rnd64(), rnd64(), 64'd1);
    random_phase(520);
    send_idle_pct = 0; recv_idle_pct = 0;
    rekey(rnd64(), rnd64(), 64'd0);
    random_phase(500);

    drain();
    $display("covered %0d blocks checked across %0d register writes, both directions",
             cipher_sb.checked, configs);
    if (cipher_sb.fails == 0 && cipher_sb.pending.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

`default_nettype wire

// ===== sim.f =====
+incdir+rtl/core
rtl/core/sm4_pkg.sv
rtl/core/sm4_if.sv
rtl/core/sm4_ram.sv
rtl/core/sm4_ctrl.sv
rtl/core/sm4_dp.sv
rtl/core/sm4_block_cipher_unit.sv
rtl/core/sm4_chk.sv
sim/tb_sm4_block_cipher_unit.sv
